FILE: src/tar_stream_deframer_unit_macros.svh
// ============================================================================
// Assertion macros for the tar stream deframer
// Shared concurrent assertion forms used by the RTL of the block.
// ============================================================================
`ifndef TAR_STREAM_DEFRAMER_UNIT_MACROS_SVH
`define TAR_STREAM_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tsd_pkg.sv
// ============================================================================
// Tar stream deframer package
// Types, codes and block layout constants shared by the deframer modules.
// ============================================================================
`default_nettype none

package tsd_pkg;

    localparam int OFF_W  = 9;
    localparam int SIZE_W = 33;
    localparam int BYTE_W = 8;

    localparam logic [OFF_W-1:0] SIZE_FIRST  = 9'd124;
    localparam logic [OFF_W-1:0] SIZE_LAST   = 9'd134;
    localparam logic [OFF_W-1:0] TYPE_OFFSET = 9'd156;
    localparam logic [OFF_W-1:0] BLOCK_LAST  = 9'd511;

    localparam logic [BYTE_W-1:0] TYPE_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_REGULAR = 8'h30;
    localparam logic [BYTE_W-1:0] TYPE_HLINK   = 8'h31;
    localparam logic [BYTE_W-1:0] TYPE_SLINK   = 8'h32;
    localparam logic [BYTE_W-1:0] TYPE_DIR     = 8'h35;

    // High five bits of an ASCII octal digit '0'..'7'.
    localparam logic [4:0] OCTAL_HIGH = 5'b00110;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_PAD    = 3'd2,
        KIND_ZERO   = 3'd3,
        KIND_END    = 3'd4,
        KIND_HALT   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ETYPE_REGULAR = 2'd0,
        ETYPE_HLINK   = 2'd1,
        ETYPE_SLINK   = 2'd2,
        ETYPE_DIR     = 2'd3
    } t_etype;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_TYPE   = 2'd1,
        ERR_AFTER_ZERO = 2'd2
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic               entry_done;
        t_etype             entry_type;
        logic [SIZE_W-1:0]  entry_size;
        logic               archive_end;
        t_err               error_code;
    } t_result;

endpackage

`default_nettype wire

FILE: src/tsd_parser.sv
// ============================================================================
// Tar stream deframer parser
// Block state machine that labels one archive byte per accepted transaction.
// ============================================================================
`default_nettype none

module tsd_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [tsd_pkg::BYTE_W-1:0]  i_byte,
    output tsd_pkg::t_result                 o_result
);
    import tsd_pkg::*;

    `include "tar_stream_deframer_unit_macros.svh"

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_DATA      = 3'd1,
        PH_PAD       = 3'd2,
        PH_END       = 3'd3,
        PH_HALT_TYPE = 3'd4,
        PH_HALT_ZERO = 3'd5
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [OFF_W-1:0]    r_off, n_off;
    logic                r_all_zero, n_all_zero;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [BYTE_W-1:0]   r_type, n_type;
    logic                r_zero_seen, n_zero_seen;
    logic [SIZE_W-1:0]   r_left, n_left;

    logic                az;
    logic [2:0]          digit;
    t_result             res;

    always_comb begin
        n_phase     = r_phase;
        n_off       = r_off;
        n_all_zero  = r_all_zero;
        n_size      = r_size;
        n_type      = r_type;
        n_zero_seen = r_zero_seen;
        n_left      = r_left;

        res             = '0;
        res.kind        = KIND_HEADER;
        res.entry_type  = ETYPE_REGULAR;
        res.error_code  = ERR_NONE;
        res.data        = i_byte;

        az    = r_all_zero && (i_byte == '0);
        digit = (i_byte[7:3] == OCTAL_HIGH) ? i_byte[2:0] : 3'd0;

        case (r_phase)
            PH_HEADER: begin
                n_all_zero = az;
                if (r_off >= SIZE_FIRST && r_off <= SIZE_LAST) begin
                    n_size = {r_size[SIZE_W-4:0], digit};
                end
                if (r_off == TYPE_OFFSET) begin
                    n_type = i_byte;
                end
                res.kind = az ? KIND_ZERO : KIND_HEADER;
                if (r_off == BLOCK_LAST) begin
                    if (az) begin
                        if (r_zero_seen) begin
                            res.archive_end = 1'b1;
                            n_phase = PH_END;
                        end else begin
                            n_zero_seen = 1'b1;
                        end
                    end else if (r_zero_seen) begin
                        res.kind       = KIND_HALT;
                        res.error_code = ERR_AFTER_ZERO;
                        n_phase        = PH_HALT_ZERO;
                    end else if (r_type == TYPE_REGULAR || r_type == TYPE_NUL) begin
                        res.entry_done = 1'b1;
                        res.entry_type = ETYPE_REGULAR;
                        res.entry_size = r_size;
                        if (r_size != '0) begin
                            n_left  = r_size;
                            n_phase = PH_DATA;
                        end
                    end else if (r_type == TYPE_HLINK) begin
                        res.entry_done = 1'b1;
                        res.entry_type = ETYPE_HLINK;
                        res.entry_size = r_size;
                    end else if (r_type == TYPE_SLINK) begin
                        res.entry_done = 1'b1;
                        res.entry_type = ETYPE_SLINK;
                        res.entry_size = r_size;
                    end else if (r_type == TYPE_DIR) begin
                        res.entry_done = 1'b1;
                        res.entry_type = ETYPE_DIR;
                        res.entry_size = r_size;
                    end else begin
                        res.kind       = KIND_HALT;
                        res.error_code = ERR_BAD_TYPE;
                        n_phase        = PH_HALT_TYPE;
                    end
                    n_off      = '0;
                    n_all_zero = 1'b1;
                    n_size     = '0;
                    n_type     = '0;
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
            PH_DATA: begin
                res.kind = KIND_DATA;
                n_off    = r_off + 1'b1;
                n_left   = r_left - 1'b1;
                if (n_left == '0) begin
                    res.last = 1'b1;
                    // Data that ends on a block boundary needs no padding.
                    if (n_off == '0) begin
                        n_all_zero = 1'b1;
                        n_size     = '0;
                        n_type     = '0;
                        n_phase    = PH_HEADER;
                    end else begin
                        n_phase = PH_PAD;
                    end
                end
            end
            PH_PAD: begin
                res.kind = KIND_PAD;
                n_off    = r_off + 1'b1;
                if (n_off == '0) begin
                    n_all_zero = 1'b1;
                    n_size     = '0;
                    n_type     = '0;
                    n_phase    = PH_HEADER;
                end
            end
            PH_END: begin
                res.kind = KIND_END;
            end
            PH_HALT_TYPE: begin
                res.kind       = KIND_HALT;
                res.error_code = ERR_BAD_TYPE;
            end
            PH_HALT_ZERO: begin
                res.kind       = KIND_HALT;
                res.error_code = ERR_AFTER_ZERO;
            end
            default: begin
                res.kind       = KIND_HALT;
                res.error_code = ERR_AFTER_ZERO;
                n_phase        = PH_HALT_ZERO;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_off       <= '0;
            r_all_zero  <= 1'b1;
            r_size      <= '0;
            r_type      <= '0;
            r_zero_seen <= 1'b0;
            r_left      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_off       <= n_off;
            r_all_zero  <= n_all_zero;
            r_size      <= n_size;
            r_type      <= n_type;
            r_zero_seen <= n_zero_seen;
            r_left      <= n_left;
        end
    end

    `TSD_ASSERT_NOW(a_left_nonzero, i_clk, i_rst_n, r_phase == PH_DATA, r_left != '0, "data phase with nothing left")
    `TSD_ASSERT_NOW(a_done_header, i_clk, i_rst_n, o_result.entry_done, o_result.kind == KIND_HEADER && r_off == BLOCK_LAST, "entry done off the last header byte")
    `TSD_ASSERT_NOW(a_err_halt, i_clk, i_rst_n, o_result.error_code != ERR_NONE, o_result.kind == KIND_HALT, "error without halt label")
    `TSD_ASSERT_NEXT(a_end_phase, i_clk, i_rst_n, i_step && o_result.archive_end, r_phase == PH_END, "archive end did not stop parsing")

endmodule

`default_nettype wire

FILE: src/tar_stream_deframer_unit.sv
// ============================================================================
// Tar stream deframer unit
// Labels a byte stream of a ustar-style archive block by block.
// ============================================================================
// Usage: archive bytes enter on the s_axis channel, one byte per transaction,
// in stream order starting with the first header block. Every input
// transaction produces exactly one output transaction on m_axis: the byte
// itself, its kind on tuser (header, file data, padding, zero block, after
// end, halted), tlast on the final data byte of a regular entry, and in
// tdata the entry report that is valid on the last byte of a good header.
// The output is registered. Throughput is one byte per cycle unless the
// receiver stalls, set by the single parser step per byte and the one output
// register; the input is taken while a result is still waiting, as long as
// that result is being taken in the same cycle.
// When the receiver stalls, the output register holds its transaction and
// s_axis_tready drops until it is taken; no byte is lost or repeated.
// Reset (synchronous, active low) empties the output register and returns
// the parser to the start of a header block with no zero block seen.
// After an error the block keeps labeling bytes as halted with the error
// code; after the second zero block it labels every byte as after end.
`default_nettype none

module tar_stream_deframer_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input stream: tdata [7:0] byte_in.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,
    // Output stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: [7:0] data_out, [8] entry_done, [10:9] entry_type,
    // [43:11] entry_size, [44] archive_end, [46:45] error_code, [47] zero.
    output logic [47:0]       m_axis_tdata,
    // tuser: [2:0] byte_kind.
    output logic [2:0]        m_axis_tuser,
    // tlast: data_last.
    output logic              m_axis_tlast
);
    import tsd_pkg::*;

    logic     accept;
    t_result  step_result;
    t_result  r_out;
    logic     r_out_valid;

    // The output register may be refilled in the cycle it drains.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_byte   (s_axis_tdata),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is only seen with the valid flag set.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.error_code, r_out.archive_end, r_out.entry_size,
                            r_out.entry_type, r_out.entry_done, r_out.data};

endmodule

`default_nettype wire
